>>> rtl/skl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants
// Entry and result layouts, opcodes and register map of the sorted key table.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int MAX_ENTRIES_DEF = 256;

	localparam int KEY_W     = 64;
	localparam int OFFSET_W  = 32;
	localparam int TYPE_W    = 8;
	localparam int SLOT_W    = 8;
	localparam int COUNT_W   = 9;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [0:0] OP_WRITE  = 1'b0;
	localparam logic [0:0] OP_LOOKUP = 1'b1;

	// register indexes (byte address is four times the index)
	localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [OFFSET_W-1:0] payload_offset;
		logic [OFFSET_W-1:0] payload_size;
		logic [OFFSET_W-1:0] name_offset;
		logic [TYPE_W-1:0]   type_code;
	} skl_entry_t;

	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   match_index;
		logic [OFFSET_W-1:0] match_payload_offset;
		logic [OFFSET_W-1:0] match_payload_size;
		logic [OFFSET_W-1:0] match_name_offset;
		logic [TYPE_W-1:0]   match_type_code;
	} skl_result_t;

endpackage
`default_nettype wire

>>> rtl/sorted_key_table_lookup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_top: sorted 64-bit key table with lower-bound lookup
//
//   channel  direction  handshake              carries
//   in       sink       in_valid / in_stall    opcode, slot, key, entry fields
//   out      source     out_valid / out_stall  found, index, entry fields
//   cfg      APB        psel/penable/pready    entry_count at byte address 0
//
// A write request leaves the request channel free. A lookup binary-searches
// the n clamped entries; a zero key or an empty table skips the probes. The
// single read port of the table memory sets one probe per cycle.
// Reset clears the entry count and the control state; table contents are
// undefined until written. A finished result waits in the output register
// while out_stall is high and the block takes the next request meanwhile.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_top #(
	parameter int MAX_ENTRIES = skl_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [skl_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [skl_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [skl_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [skl_pkg::SLOT_W-1:0]        entry_index,
	input  wire logic [skl_pkg::KEY_W-1:0]         key,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      payload_offset,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      payload_size,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      name_offset,
	input  wire logic [skl_pkg::TYPE_W-1:0]        type_code,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   found,
	output logic      [skl_pkg::SLOT_W-1:0]        match_index,
	output logic      [skl_pkg::OFFSET_W-1:0]      match_payload_offset,
	output logic      [skl_pkg::OFFSET_W-1:0]      match_payload_size,
	output logic      [skl_pkg::OFFSET_W-1:0]      match_name_offset,
	output logic      [skl_pkg::TYPE_W-1:0]        match_type_code
);
	import skl_pkg::*;

	logic [COUNT_W-1:0] entry_count;
	skl_entry_t         in_entry;
	skl_result_t        out_result;

	assign in_entry.key            = key;
	assign in_entry.payload_offset = payload_offset;
	assign in_entry.payload_size   = payload_size;
	assign in_entry.name_offset    = name_offset;
	assign in_entry.type_code      = type_code;

	skl_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	skl_engine #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_opcode   (opcode),
		.in_slot     (entry_index),
		.in_entry    (in_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_result  (out_result)
	);

	assign found                = out_result.found;
	assign match_index          = out_result.match_index;
	assign match_payload_offset = out_result.match_payload_offset;
	assign match_payload_size   = out_result.match_payload_size;
	assign match_name_offset    = out_result.match_name_offset;
	assign match_type_code      = out_result.match_type_code;

endmodule
`default_nettype wire

>>> rtl/skl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module skl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/skl_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skl_cfg: configuration register port
// APB-style access to the entry count register.
// ----------------------------------------------------------------------------
module skl_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [skl_pkg::CFG_ADDR_W-1:0]       paddr,
	input  wire logic [skl_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic      [skl_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                      pready,
	output logic      [skl_pkg::COUNT_W-1:0]          entry_count
);
	import skl_pkg::*;

	logic [COUNT_W-1:0] entry_count_q;
	logic               reg_idx;
	logic               wr_en;

	assign reg_idx = paddr[CFG_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (wr_en && reg_idx == REG_ENTRY_COUNT) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ENTRY_COUNT) begin
			prdata = CFG_DATA_W'(entry_count_q);
		end
	end

	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

>>> rtl/skl_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skl_engine: table memory and lower-bound search sequencer
// Writes load one entry; lookups probe the memory once a cycle, then read the
// lower-bound entry and compare it to the searched key.
// ----------------------------------------------------------------------------
module skl_engine #(
	parameter int MAX_ENTRIES = skl_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [skl_pkg::COUNT_W-1:0]   entry_count,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          in_opcode,
	input  wire logic [skl_pkg::SLOT_W-1:0]    in_slot,
	input  wire skl_pkg::skl_entry_t           in_entry,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output skl_pkg::skl_result_t               out_result
);
	import skl_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_FINAL = 2'd2;

	logic [1:0]         state_q;
	logic               out_valid_q;
	skl_result_t        result_q;
	logic [KEY_W-1:0]   k_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      span_q;
	logic [CW-1:0]      half_q;
	logic [CW-1:0]      probe_q;
	logic               miss_q;

	logic               accept;
	logic               do_write;
	logic               start;
	logic [CW-1:0]      n_c;
	logic [CW-1:0]      half0;
	logic               less;
	logic [CW-1:0]      new_lo;
	logic [CW-1:0]      new_span;
	logic [CW-1:0]      nh;
	logic [CW-1:0]      np;
	logic               emit;
	logic               hit;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	skl_entry_t         ram_rdata;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign do_write = accept && in_opcode == OP_WRITE && 32'(in_slot) < MAX_ENTRIES;

	// clamp the register to the table depth
	assign n_c   = (32'(entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_count);
	assign half0 = n_c >> 1;
	assign start = accept && in_opcode == OP_LOOKUP;

	assign less     = ram_rdata.key < k_q;
	assign new_lo   = less ? probe_q + CW'(1) : lo_q;
	assign new_span = less ? span_q - half_q - CW'(1) : half_q;
	assign nh       = new_span >> 1;
	assign np       = new_lo + nh;

	assign emit = (state_q == S_FINAL) && (!out_valid_q || !out_stall);
	assign hit  = !miss_q && ram_rdata.key == k_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (start && in_entry.key != '0 && n_c != '0) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(half0);
				end
			end
			S_PROBE: begin
				if (new_span == '0) begin
					ram_re    = (new_lo < n_q);
					ram_raddr = AW'(new_lo);
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(np);
				end
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = '0;
			end
		endcase
	end

	skl_ram #(
		.WIDTH ($bits(skl_entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (do_write),
		.waddr (AW'(in_slot)),
		.wdata (in_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (in_entry.key == '0 || n_c == '0) begin
							state_q <= S_FINAL;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (new_span == '0) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			k_q     <= in_entry.key;
			n_q     <= n_c;
			lo_q    <= '0;
			span_q  <= n_c;
			half_q  <= half0;
			probe_q <= half0;
			miss_q  <= (in_entry.key == '0 || n_c == '0);
		end
		if (state_q == S_PROBE) begin
			lo_q    <= new_lo;
			span_q  <= new_span;
			half_q  <= nh;
			probe_q <= np;
			if (new_span == '0) begin
				miss_q <= !(new_lo < n_q);
			end
		end
		if (emit) begin
			result_q.found                <= hit;
			result_q.match_index          <= hit ? SLOT_W'(lo_q) : '0;
			result_q.match_payload_offset <= hit ? ram_rdata.payload_offset : '0;
			result_q.match_payload_size   <= hit ? ram_rdata.payload_size : '0;
			result_q.match_name_offset    <= hit ? ram_rdata.name_offset : '0;
			result_q.match_type_code      <= hit ? ram_rdata.type_code : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

endmodule
`default_nettype wire

>>> rtl/skl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skl_checker: port-level checks for the sorted key table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module skl_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              opcode,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic                              found,
	input  wire logic [skl_pkg::SLOT_W-1:0]        match_index,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      match_payload_offset,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      match_payload_size,
	input  wire logic [skl_pkg::OFFSET_W-1:0]      match_name_offset,
	input  wire logic [skl_pkg::TYPE_W-1:0]        match_type_code
);
	import skl_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_index)
			&& $stable(match_payload_offset))
		else $error("stalled result changed");

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_index == '0 && match_payload_offset == '0
			&& match_payload_size == '0 && match_name_offset == '0
			&& match_type_code == '0)
		else $error("miss result with nonzero fields");

	// a lookup request holds the request channel stalled after it is accepted
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_LOOKUP |=> in_stall)
		else $error("lookup did not hold the request channel");

	// a write request completes at once
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_WRITE |=> !in_stall)
		else $error("write request stalled the next request");

endmodule

bind sorted_key_table_lookup_top skl_checker u_skl_checker (.*);
`default_nettype wire
